>>> rtl/dsrs_pkg.sv
// Shared constants and types for the descending stable record sorter.
package dsrs_pkg;

  localparam int DSRS_MAX_ENTRIES = 64;
  localparam int DSRS_KEY_BITS    = 16;
  localparam int DSRS_TAG_BITS    = 12;

  // Chain-wide control that the top level broadcasts to every cell.
  typedef struct packed {
    logic load;       // insert the new record into the chain
    logic shift_out;  // move every record one cell toward the output
  } dsrs_ctl_t;

endpackage

>>> rtl/dsrs_cell.sv
// One cell of the sorting chain: holds one record and trades it with its neighbors.
module dsrs_cell import dsrs_pkg::*; #(
  parameter int KEY_BITS = DSRS_KEY_BITS,
  parameter int TAG_BITS = DSRS_TAG_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dsrs_ctl_t           ctl,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [TAG_BITS-1:0] new_tag,
  input  logic                left_valid,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic [TAG_BITS-1:0] left_tag,
  input  logic                left_ins,
  input  logic                right_valid,
  input  logic [KEY_BITS-1:0] right_key,
  input  logic [TAG_BITS-1:0] right_tag,
  output logic                valid,
  output logic [KEY_BITS-1:0] key,
  output logic [TAG_BITS-1:0] tag,
  output logic                ins
);

  logic                valid_r, valid_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;

  // The new record belongs here or further up when this cell is empty or
  // holds a strictly smaller key; equal keys stay ahead of it.
  assign ins = !valid_r || (key_r < new_key);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    tag_nxt   = tag_r;
    if (ctl.shift_out) begin
      valid_nxt = right_valid;
      key_nxt   = right_key;
      tag_nxt   = right_tag;
    end else if (ctl.load) begin
      if (left_ins) begin
        valid_nxt = left_valid;
        key_nxt   = left_key;
        tag_nxt   = left_tag;
      end else if (ins) begin
        valid_nxt = 1'b1;
        key_nxt   = new_key;
        tag_nxt   = new_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign tag   = tag_r;

endmodule

>>> rtl/descending_stable_record_sorter.sv
// Top level of the descending stable record sorter: insertion chain and run control.
//
// Usage: records arrive on the in_ stream, one per request, with the key in
// the low bits of in_tdata and the tag above it. Each record is inserted into
// a chain of MAX_ENTRIES cells in the cycle it is accepted, so loading runs at
// one request per cycle. The request with in_tlast set is part of the set and
// closes it. From the next cycle on, the chain drains through the out_ stream,
// largest key first, one request per cycle while out_tready is high; equal
// keys leave in arrival order. out_tlast marks the final record of the run and
// out_tuser carries the overflow bit, set on every record of a set that had
// more than MAX_ENTRIES records; the extra records are dropped, a closing one
// included. The first result is valid the cycle after the closing request.
// While results are pending in_tready stays low; a stall on out_tready simply
// holds the head record, since results come straight from the first cell.
// The chain is empty again once the last result is taken, and in_tready rises
// in the following cycle. Reset empties the chain and clears the overflow bit.
module descending_stable_record_sorter import dsrs_pkg::*; #(
  parameter int MAX_ENTRIES = DSRS_MAX_ENTRIES,
  parameter int KEY_BITS    = DSRS_KEY_BITS,
  parameter int TAG_BITS    = DSRS_TAG_BITS,
  localparam int DATA_BITS  = ((KEY_BITS + TAG_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DATA_BITS-1:0] in_tdata,   // sort_key, payload_tag, zero pad
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_BITS-1:0] out_tdata,  // out_key, out_tag, zero pad
  output logic                 out_tlast,
  output logic                 out_tuser   // overflow
);

  localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
  localparam int PAD_BITS = DATA_BITS - KEY_BITS - TAG_BITS;
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(MAX_ENTRIES);
  localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);

  logic                emit_r, emit_nxt;
  logic                drop_r, drop_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;

  logic                in_fire, out_fire, full;
  logic [KEY_BITS-1:0] new_key;
  logic [TAG_BITS-1:0] new_tag;
  dsrs_ctl_t           ctl;

  logic                cell_valid [MAX_ENTRIES];
  logic [KEY_BITS-1:0] cell_key   [MAX_ENTRIES];
  logic [TAG_BITS-1:0] cell_tag   [MAX_ENTRIES];
  logic                cell_ins   [MAX_ENTRIES];

  assign new_key   = in_tdata[KEY_BITS-1:0];
  assign new_tag   = in_tdata[KEY_BITS+TAG_BITS-1:KEY_BITS];
  assign in_tready = !emit_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign full      = (count_r == CNT_FULL);

  // A record that finds the chain full is dropped and flags overflow; a dropped closing record still starts the drain.
  assign ctl.load      = in_fire && !full;
  assign ctl.shift_out = out_fire;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic                l_valid, l_ins, r_valid;
    logic [KEY_BITS-1:0] l_key, r_key;
    logic [TAG_BITS-1:0] l_tag, r_tag;

    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_key   = '0;
      assign l_tag   = '0;
      assign l_ins   = 1'b0;
    end else begin : g_mid
      assign l_valid = cell_valid[i-1];
      assign l_key   = cell_key[i-1];
      assign l_tag   = cell_tag[i-1];
      assign l_ins   = cell_ins[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_key   = '0;
      assign r_tag   = '0;
    end else begin : g_body
      assign r_valid = cell_valid[i+1];
      assign r_key   = cell_key[i+1];
      assign r_tag   = cell_tag[i+1];
    end

    dsrs_cell #(
      .KEY_BITS (KEY_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_key     (new_key),
      .new_tag     (new_tag),
      .left_valid  (l_valid),
      .left_key    (l_key),
      .left_tag    (l_tag),
      .left_ins    (l_ins),
      .right_valid (r_valid),
      .right_key   (r_key),
      .right_tag   (r_tag),
      .valid       (cell_valid[i]),
      .key         (cell_key[i]),
      .tag         (cell_tag[i]),
      .ins         (cell_ins[i])
    );
  end

  // Run control: count stored records and flag drops while loading, start the
  // drain on tlast, count down while draining, and end the run on the last result.
  always_comb begin
    emit_nxt  = emit_r;
    drop_nxt  = drop_r;
    count_nxt = count_r;
    if (in_fire) begin
      if (full) begin
        drop_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_ONE;
      end
      if (in_tlast) begin
        emit_nxt = 1'b1;
      end
    end else if (out_fire) begin
      count_nxt = count_r - CNT_ONE;
      if (count_r == CNT_ONE) begin
        emit_nxt = 1'b0;
        drop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r  <= 1'b0;
      drop_r  <= 1'b0;
      count_r <= '0;
    end else begin
      emit_r  <= emit_nxt;
      drop_r  <= drop_nxt;
      count_r <= count_nxt;
    end
  end

  // Results come straight from the head cell.
  assign out_tvalid = emit_r;
  assign out_tlast  = (count_r == CNT_ONE);
  assign out_tuser  = drop_r;
  if (PAD_BITS > 0) begin : g_pad
    assign out_tdata = {{PAD_BITS{1'b0}}, cell_tag[0], cell_key[0]};
  end else begin : g_nopad
    assign out_tdata = {cell_tag[0], cell_key[0]};
  end

  // A pending result always has a stored record behind it.
  a_emit_has_records: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (count_r != '0))
    else $error("result offered with an empty chain");

  // The head cell is occupied exactly when the record count is nonzero.
  a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[0] == (count_r != '0))
    else $error("head cell occupancy disagrees with record count");

  // A closing request starts the drain in the next cycle.
  a_last_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> out_tvalid)
    else $error("closing request did not start the drain");

  // Taking the final result leaves the chain empty and ready for a new set.
  a_run_ends_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_tlast) |=> (!out_tvalid && count_r == '0 && !cell_valid[0]))
    else $error("chain not empty after the final result");

endmodule

>>> tb/sorted_run_checker.sv
// Checker that predicts the sorted runs of the record sorter and compares each result.
module sorted_run_checker import dsrs_pkg::*; #(
  parameter int DATA_BITS = ((DSRS_KEY_BITS + DSRS_TAG_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [DATA_BITS-1:0] in_tdata,   // sort_key, payload_tag, zero pad
  input  logic                 in_tlast,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [DATA_BITS-1:0] out_tdata,  // out_key, out_tag, zero pad
  input  logic                 out_tlast,
  input  logic                 out_tuser,  // overflow
  output int                   fail_count,
  output int                   pending,
  output int                   results_seen,
  output int                   sets_closed,
  output int                   overflow_sets
);

  typedef struct packed {
    logic [DSRS_KEY_BITS-1:0] key;
    logic [DSRS_TAG_BITS-1:0] tag;
  } record_t;

  typedef struct packed {
    record_t rec;
    logic    last;
    logic    overflow;
  } rank_t;

  record_t arrivals[$];        // records of the open set, in arrival order
  record_t ranked[$];          // the closed set, largest key first
  rank_t   expected_ranks[$];  // results still to come, oldest first
  logic    set_dropped = 1'b0;

  initial begin
    fail_count    = 0;
    pending       = 0;
    results_seen  = 0;
    sets_closed   = 0;
    overflow_sets = 0;
  end

  always @(posedge clk) begin : watch
    record_t rec;
    rank_t   want;
    rank_t   got;
    int      pos;
    if (!rst_n) begin
      arrivals.delete();
      expected_ranks.delete();
      set_dropped = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.rec.key  = out_tdata[DSRS_KEY_BITS-1:0];
        got.rec.tag  = out_tdata[DSRS_KEY_BITS+DSRS_TAG_BITS-1:DSRS_KEY_BITS];
        got.last     = out_tlast;
        got.overflow = out_tuser;
        if (expected_ranks.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: key %0d tag %0d last %0b overflow %0b",
                   $time, got.rec.key, got.rec.tag, got.last, got.overflow);
        end else begin
          want = expected_ranks.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: result mismatch: expected key %0d tag %0d last %0b overflow %0b",
                     $time, want.rec.key, want.rec.tag, want.last, want.overflow);
            $display("%0t:                  actual key %0d tag %0d last %0b overflow %0b",
                     $time, got.rec.key, got.rec.tag, got.last, got.overflow);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        rec.key = in_tdata[DSRS_KEY_BITS-1:0];
        rec.tag = in_tdata[DSRS_KEY_BITS+DSRS_TAG_BITS-1:DSRS_KEY_BITS];
        if (arrivals.size() < DSRS_MAX_ENTRIES) arrivals.push_back(rec);
        else set_dropped = 1'b1;
        if (in_tlast) begin
          // Stable descending order: each record goes in front of the first
          // one with a strictly smaller key, so equal keys keep arrival order.
          ranked.delete();
          foreach (arrivals[i]) begin
            pos = ranked.size();
            for (int j = 0; j < ranked.size(); j++) begin
              if (ranked[j].key < arrivals[i].key) begin
                pos = j;
                break;
              end
            end
            ranked.insert(pos, arrivals[i]);
          end
          foreach (ranked[i]) begin
            want.rec      = ranked[i];
            want.last     = (i == ranked.size() - 1);
            want.overflow = set_dropped;
            expected_ranks.push_back(want);
          end
          sets_closed++;
          if (set_dropped) overflow_sets++;
          arrivals.delete();
          set_dropped = 1'b0;
        end
      end
    end
    pending = expected_ranks.size();
  end

endmodule

>>> tb/descending_stable_record_sorter_test.sv
// Top of the record sorter testbench: clock, reset, stimulus and verdict.
module descending_stable_record_sorter_test import dsrs_pkg::*;;

  localparam int DATA_BITS   = ((DSRS_KEY_BITS + DSRS_TAG_BITS + 7) / 8) * 8;
  localparam int PAD_BITS    = DATA_BITS - DSRS_KEY_BITS - DSRS_TAG_BITS;
  // Watchdog limit, far beyond the slowest correct run.
  localparam int CYCLE_LIMIT = 50000;
  // The first result comes the cycle after the closing request, so a short
  // drain after the last expected result is enough to catch stray output.
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 220;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [DATA_BITS-1:0] in_tdata   = '0;   // sort_key, payload_tag, zero pad
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DATA_BITS-1:0] out_tdata;         // out_key, out_tag, zero pad
  logic                 out_tlast;
  logic                 out_tuser;         // overflow

  int fail_count;
  int pending;
  int results_seen;
  int sets_closed;
  int overflow_sets;
  int items_sent  = 0;
  int cycle_count = 0;

  // While steady is set neither side idles; the random part raises it for a
  // long stretch in the middle of the run.
  logic steady = 1'b0;

  descending_stable_record_sorter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  sorted_run_checker #(.DATA_BITS(DATA_BITS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .sets_closed   (sets_closed),
    .overflow_sets (overflow_sets)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Unless steady is set, the receiver stalls at random, about nine times in a
  // hundred; as results drain one per ready cycle, stalls hit random ranks.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 9);
  end

  // Offer one record and hold it until the sorter takes the request. An
  // optional idle gap comes first; in_tvalid is lowered only when a gap is
  // taken, so it never gets two assignments in the same step.
  task automatic offer_record(input logic [DSRS_KEY_BITS-1:0] key,
                              input logic [DSRS_TAG_BITS-1:0] tag,
                              input logic                     last);
    if (!steady && $urandom_range(0, 99) < 9) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_BITS{1'b0}}, tag, key};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int                       random_items;
    int                       set_index;
    int                       set_size;
    int                       pick;
    logic [DSRS_KEY_BITS-1:0] key;
    logic [DSRS_TAG_BITS-1:0] tag;

    random_items = 0;
    set_index    = 0;

    // Reset is held low from the start and released at a rising edge.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets. The first mixes both key extremes with ties on them and
    // both tag extremes.
    offer_record(16'hFFFF, 12'hFFF, 1'b0);
    offer_record(16'h0000, 12'h000, 1'b0);
    offer_record(16'hFFFF, 12'h001, 1'b0);
    offer_record(16'h0000, 12'hFFE, 1'b0);
    offer_record(16'h8000, 12'h800, 1'b1);
    // A set of one record, closed by its only request.
    offer_record(16'd1234, 12'd7, 1'b1);
    // All keys equal: the run must come out in arrival order.
    offer_record(16'd5, 12'd10, 1'b0);
    offer_record(16'd5, 12'd11, 1'b0);
    offer_record(16'd5, 12'd12, 1'b0);
    offer_record(16'd5, 12'd13, 1'b1);
    // Ascending keys, so that each new record goes in at the head of the chain.
    offer_record(16'd1, 12'd100, 1'b0);
    offer_record(16'd2, 12'd200, 1'b0);
    offer_record(16'd3, 12'd300, 1'b0);
    offer_record(16'd4, 12'd400, 1'b1);
    // Already descending, so each new record goes in behind the ones before it.
    offer_record(16'd9, 12'd1, 1'b0);
    offer_record(16'd8, 12'd2, 1'b0);
    offer_record(16'd7, 12'd3, 1'b1);
    // A lone zero record.
    offer_record(16'h0000, 12'h000, 1'b1);

    // Random sets. Most are small; one fills the store exactly and one runs
    // past it, so that the records beyond capacity, the closing one among
    // them, are dropped and the run carries the overflow bit.
    while (random_items < RANDOM_ITEMS) begin
      case (set_index)
        2:       set_size = DSRS_MAX_ENTRIES;
        5:       set_size = DSRS_MAX_ENTRIES + 2;
        default: set_size = $urandom_range(1, 12);
      endcase
      for (int k = 0; k < set_size; k++) begin
        steady = (random_items >= 90) && (random_items < 150);
        // Small keys make ties common; extremes show up now and then.
        pick = $urandom_range(0, 99);
        if (pick < 30) key = DSRS_KEY_BITS'($urandom_range(0, 3));
        else if (pick < 40) key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else key = DSRS_KEY_BITS'($urandom_range(0, 16'hFFFF));
        tag = DSRS_TAG_BITS'($urandom_range(0, 12'hFFF));
        offer_record(key, tag, k == set_size - 1);
        random_items++;
      end
      set_index++;
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    // Wait until the last run is drained, then give stray output a chance.
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d records in %0d sets; %0d sets overflowed the store.",
             items_sent, sets_closed, overflow_sets);
    $display("Checked %0d sorted results against the prediction.", results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
